// ===== rtl/sni_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sni_pkg;

    typedef enum logic [4:0] {
        PH_HDR, PH_SKIP_RANDOM, PH_SID_LEN, PH_SKIP_SID, PH_CS_LEN, PH_SKIP_CS,
        PH_COMP_LEN, PH_SKIP_COMP, PH_EXTS_LEN, PH_EXT_TYPE, PH_EXT_LEN_SNI,
        PH_EXT_LEN_OTHER, PH_SKIP_EXT, PH_LIST_LEN, PH_NAME_TYPE, PH_NAME_LEN_HOST,
        PH_NAME_LEN_OTHER, PH_SKIP_NAME, PH_NAME_CHARS, PH_DONE, PH_FAIL
    } phase_t;

    localparam int POS_W = 25;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0] NAME_HOST = 8'h00;
    localparam int HELLO_FIXED_END = 9 + 2 + 32;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] MAX_NAME_RESET = 8'd253;

    // Result item handed from the parser to the output queue.
    typedef struct packed {
        logic [6:0] name_char;
        logic       char_valid;
        logic       verdict_done;
        logic       sni_found;
        logic [7:0] name_length;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/tls_sni_host_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Extracts the first SNI host name from a TLS ClientHello, one payload byte per
// cycle. Each accepted byte is parsed in the same cycle; a character or a verdict
// goes into a two-entry result queue, so bytes keep flowing at one per cycle as
// long as the master side takes results. Each result is registered in the queue.
module tls_sni_host_extractor
    import sni_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // name_char[6:0], sni_found[7], name_length[15:8]
    output logic             m_tlast,   // verdict_done
    output logic             m_tuser    // char_valid
);

    logic [7:0] max_reg;
    result_t    res, q;
    logic       res_valid, q_ok;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_NAME_RESET;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_wdata;
        end
    end

    // Accept only when the result queue has room, whether or not the byte makes a result.
    assign s_tready = q_ok;

    sni_parser u_parser (
        .clk, .rst_n, .step(s_tvalid && s_tready), .data_byte(s_tdata),
        .last_byte(s_tlast), .max_name_chars(max_reg), .res, .res_valid
    );

    sni_queue #(.DEPTH(DEPTH)) u_queue (
        .clk, .rst_n, .wr_en(s_tvalid && s_tready && res_valid), .wr_data(res),
        .wr_ok(q_ok), .rd_valid(m_tvalid), .rd_en(m_tready), .rd_data(q)
    );

    assign m_tdata = {q.name_length, q.sni_found, q.name_char};
    assign m_tlast = q.verdict_done;
    assign m_tuser = q.char_valid;

endmodule
`default_nettype wire

// ===== rtl/sni_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sni_parser
    import sni_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic [7:0] max_name_chars,
    output result_t         res,
    output logic            res_valid
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [23:0]       acc_reg, acc_next;
    logic [1:0]        left_reg, left_next;
    logic [POS_W-1:0]  hs_end_reg, hs_end_next;
    logic [POS_W-1:0]  exts_end_reg, exts_end_next;
    logic [POS_W-1:0]  ext_end_reg, ext_end_next;
    logic [POS_W-1:0]  list_end_reg, list_end_next;
    logic [23:0]       skip_reg, skip_next;
    logic [15:0]       name_rem_reg, name_rem_next;
    logic [7:0]        count_reg, count_next;
    logic              complete_reg, complete_next;
    logic              failed_reg, failed_next;

    logic [POS_W+1:0] nx;
    logic [15:0]      acc2;
    logic             got2;
    logic [23:0]      acc3;
    logic [23:0]      skip_dec;
    logic             is_host;
    logic [7:0]       lower;
    logic             emit;
    logic             found;

    // Map a skip phase to the phase after it.
    function automatic phase_t after_skip(input phase_t ph);
        case (ph)
            PH_SKIP_RANDOM: after_skip = PH_SID_LEN;
            PH_SKIP_SID:    after_skip = PH_CS_LEN;
            PH_SKIP_CS:     after_skip = PH_COMP_LEN;
            PH_SKIP_COMP:   after_skip = PH_EXTS_LEN;
            PH_SKIP_EXT:    after_skip = PH_EXT_TYPE;
            default:        after_skip = PH_NAME_TYPE;
        endcase
    endfunction

    // End-of-region check for entering a phase whose first byte is at nx.
    function automatic logic enter_fails(input phase_t ph, input logic [POS_W+1:0] n,
                                         input logic [POS_W-1:0] xe,
                                         input logic [POS_W-1:0] le);
        enter_fails = ((ph == PH_EXT_TYPE) && (n + 27'd4 > {2'b0, xe})) ||
                      ((ph == PH_NAME_TYPE) && (n + 27'd3 > {2'b0, le}));
    endfunction

    // Clocked state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            pos_reg      <= '0;
            acc_reg      <= '0;
            left_reg     <= '0;
            hs_end_reg   <= '0;
            exts_end_reg <= '0;
            ext_end_reg  <= '0;
            list_end_reg <= '0;
            skip_reg     <= '0;
            name_rem_reg <= '0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            hs_end_reg   <= hs_end_next;
            exts_end_reg <= exts_end_next;
            ext_end_reg  <= ext_end_next;
            list_end_reg <= list_end_next;
            skip_reg     <= skip_next;
            name_rem_reg <= name_rem_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
            failed_reg   <= failed_next;
        end
    end

    // Per-byte parse step.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        hs_end_next   = hs_end_reg;
        exts_end_next = exts_end_reg;
        ext_end_next  = ext_end_reg;
        list_end_next = list_end_reg;
        skip_next     = skip_reg;
        name_rem_next = name_rem_reg;
        count_next    = count_reg;
        complete_next = complete_reg;
        failed_next   = failed_reg;
        emit          = 1'b0;
        lower         = data_byte;

        nx   = {2'b0, pos_reg} + 27'd1;
        acc2 = {acc_reg[7:0], data_byte};
        got2 = (left_reg <= 2'd1);
        acc3 = {acc_reg[15:0], data_byte};
        skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;
        is_host = (data_byte >= 8'h61 && data_byte <= 8'h7a) ||
                  (data_byte >= 8'h41 && data_byte <= 8'h5a) ||
                  (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                  data_byte == 8'h2d || data_byte == 8'h2e || data_byte == 8'h5f;
        if (data_byte >= 8'h41 && data_byte <= 8'h5a)
        begin
            lower = data_byte + 8'd32;
        end

        case (phase_reg)
            PH_HDR:
            begin
                if (pos_reg == 25'd0 && data_byte != REC_HANDSHAKE)
                begin
                    failed_next = 1'b1; phase_next = PH_FAIL;
                end
                else if (pos_reg == 25'd5 && data_byte != HS_CLIENT_HELLO)
                begin
                    failed_next = 1'b1; phase_next = PH_FAIL;
                end
                else if (pos_reg >= 25'd6)
                begin
                    acc_next = acc3;
                    if (pos_reg == 25'd8)
                    begin
                        hs_end_next = 25'd9 + {1'b0, acc3};
                        if (25'(HELLO_FIXED_END + 1) > 25'd9 + {1'b0, acc3})
                        begin
                            failed_next = 1'b1; phase_next = PH_FAIL;
                        end
                        else
                        begin
                            skip_next  = 24'd34;
                            phase_next = PH_SKIP_RANDOM;
                        end
                    end
                end
            end
            PH_SKIP_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_COMP, PH_SKIP_EXT,
            PH_SKIP_NAME:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    if (enter_fails(after_skip(phase_reg), nx, exts_end_reg, list_end_reg))
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = after_skip(phase_reg);
                        left_next = 2'd2; acc_next = '0;
                    end
                end
            end
            PH_SID_LEN, PH_COMP_LEN:
            begin
                if (nx + {19'b0, data_byte} + 27'd2 > {2'b0, hs_end_reg})
                begin
                    failed_next = 1'b1; phase_next = PH_FAIL;
                end
                else if (data_byte == 8'd0)
                begin
                    phase_next = (phase_reg == PH_SID_LEN) ? PH_CS_LEN : PH_EXTS_LEN;
                    left_next = 2'd2; acc_next = '0;
                end
                else
                begin
                    skip_next  = {16'b0, data_byte};
                    phase_next = (phase_reg == PH_SID_LEN) ? PH_SKIP_SID : PH_SKIP_COMP;
                end
            end
            PH_CS_LEN:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    if (nx + {11'b0, acc2} + 27'd1 > {2'b0, hs_end_reg})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else if (acc2 == 16'd0)
                    begin
                        phase_next = PH_COMP_LEN; left_next = 2'd2; acc_next = '0;
                    end
                    else
                    begin
                        skip_next = {8'b0, acc2}; phase_next = PH_SKIP_CS;
                    end
                end
            end
            PH_EXTS_LEN:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    if (nx + {11'b0, acc2} > {2'b0, hs_end_reg})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else
                    begin
                        exts_end_next = 25'(nx + {11'b0, acc2});
                        if (27'd4 > {11'b0, acc2})
                        begin
                            failed_next = 1'b1; phase_next = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_EXT_TYPE; left_next = 2'd2; acc_next = '0;
                        end
                    end
                end
            end
            PH_EXT_TYPE:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    phase_next = (acc2 == EXT_SERVER_NAME) ? PH_EXT_LEN_SNI : PH_EXT_LEN_OTHER;
                    left_next = 2'd2; acc_next = '0;
                end
            end
            PH_EXT_LEN_SNI, PH_EXT_LEN_OTHER:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    if (nx + {11'b0, acc2} > {2'b0, exts_end_reg})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else if (phase_reg == PH_EXT_LEN_OTHER)
                    begin
                        if (acc2 != 16'd0)
                        begin
                            skip_next = {8'b0, acc2}; phase_next = PH_SKIP_EXT;
                        end
                        else if (nx + 27'd4 > {2'b0, exts_end_reg})
                        begin
                            failed_next = 1'b1; phase_next = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_EXT_TYPE; left_next = 2'd2; acc_next = '0;
                        end
                    end
                    else if (acc2 < 16'd2)
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else
                    begin
                        ext_end_next = 25'(nx + {11'b0, acc2});
                        phase_next = PH_LIST_LEN; left_next = 2'd2; acc_next = '0;
                    end
                end
            end
            PH_LIST_LEN:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    if (nx + {11'b0, acc2} > {2'b0, ext_end_reg})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else
                    begin
                        list_end_next = 25'(nx + {11'b0, acc2});
                        if (27'd3 > {11'b0, acc2})
                        begin
                            failed_next = 1'b1; phase_next = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_NAME_TYPE; left_next = 2'd2; acc_next = '0;
                        end
                    end
                end
            end
            PH_NAME_TYPE:
            begin
                phase_next = (data_byte == NAME_HOST) ? PH_NAME_LEN_HOST : PH_NAME_LEN_OTHER;
                left_next = 2'd2; acc_next = '0;
            end
            PH_NAME_LEN_HOST, PH_NAME_LEN_OTHER:
            begin
                acc_next = {8'b0, acc2};
                left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (got2)
                begin
                    if (nx + {11'b0, acc2} > {2'b0, list_end_reg})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else if (phase_reg == PH_NAME_LEN_OTHER)
                    begin
                        if (acc2 != 16'd0)
                        begin
                            skip_next = {8'b0, acc2}; phase_next = PH_SKIP_NAME;
                        end
                        else if (nx + 27'd3 > {2'b0, list_end_reg})
                        begin
                            failed_next = 1'b1; phase_next = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_NAME_TYPE; left_next = 2'd2; acc_next = '0;
                        end
                    end
                    else if (acc2 == 16'd0 || acc2 > {8'b0, max_name_chars})
                    begin
                        failed_next = 1'b1; phase_next = PH_FAIL;
                    end
                    else
                    begin
                        name_rem_next = acc2; phase_next = PH_NAME_CHARS;
                    end
                end
            end
            PH_NAME_CHARS:
            begin
                if (!is_host)
                begin
                    failed_next = 1'b1; phase_next = PH_FAIL;
                end
                else
                begin
                    emit = 1'b1;
                    count_next = count_reg + 1'b1;
                    name_rem_next = (name_rem_reg != '0) ? name_rem_reg - 1'b1 : name_rem_reg;
                    if (name_rem_next == '0)
                    begin
                        complete_next = 1'b1; phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        found = complete_next && !failed_next &&
                ({1'b0, pos_reg} + 26'd1 >= {1'b0, hs_end_next});

        res.name_char    = emit ? lower[6:0] : 7'd0;
        res.char_valid   = emit;
        res.verdict_done = last_byte;
        res.sni_found    = last_byte && found;
        res.name_length  = last_byte ? count_next : 8'd0;
        res_valid        = emit || last_byte;

        // A verdict ends the payload; start the next one from reset.
        if (last_byte)
        begin
            phase_next = PH_HDR; pos_next = '0; acc_next = '0; left_next = '0;
            hs_end_next = '0; exts_end_next = '0; ext_end_next = '0;
            list_end_next = '0; skip_next = '0; name_rem_next = '0;
            count_next = '0; complete_next = 1'b0; failed_next = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sni_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sni_queue
    import sni_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         wr_ok,
    output logic         rd_valid,
    input  wire logic    rd_en,
    output result_t      rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t        mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           do_wr, do_rd;

    assign wr_ok    = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_en && wr_ok;
    assign do_rd    = rd_en && rd_valid;

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sni_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sni_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // A result that is neither a character nor a verdict is never produced.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tlast)) else $error("empty result");

    // A found verdict always reports a nonzero name length.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && m_tdata[7]) |-> (m_tdata[15:8] != 8'd0))
        else $error("found with zero length");

    // Without a character the char field is zero.
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[6:0] == 7'd0)) else $error("stray char");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("drop");

endmodule

bind tls_sni_host_extractor sni_checker u_chk (
    .clk, .rst_n, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import sni_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [15:0] m_tdata;
    wire         m_tlast;
    wire         m_tuser;

    tls_sni_host_extractor u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #10 clk = ~clk;

    // Parser state mirrored at the block's widths.
    phase_t      ph;
    logic [24:0] pos;
    logic [23:0] acc;
    logic [1:0]  fld_left;
    logic [24:0] hs_end, exts_end, ext_end, list_end;
    logic [23:0] skip_left;
    logic [15:0] name_left;
    logic [7:0]  n_chars;
    logic        name_done, failed;
    logic [7:0]  max_chars;

    result_t     sni_expected[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    int          hold_off = 0;
    bit          stall_enable = 1'b1;

    // Simple byte-buffer used to build each payload.
    byte unsigned pkt[$];

    task automatic clear_parse();
        ph = PH_HDR; pos = '0; acc = '0; fld_left = '0; hs_end = '0; exts_end = '0;
        ext_end = '0; list_end = '0; skip_left = '0; name_left = '0; n_chars = '0;
        name_done = 1'b0; failed = 1'b0;
    endtask

    task automatic mark_fail();
        failed = 1'b1;
        ph = PH_FAIL;
    endtask

    function automatic phase_t phase_after_skip(phase_t p);
        case (p)
            PH_SKIP_RANDOM: return PH_SID_LEN;
            PH_SKIP_SID:    return PH_CS_LEN;
            PH_SKIP_CS:     return PH_COMP_LEN;
            PH_SKIP_COMP:   return PH_EXTS_LEN;
            PH_SKIP_EXT:    return PH_EXT_TYPE;
            default:        return PH_NAME_TYPE;
        endcase
    endfunction

    task automatic enter_phase(phase_t p, longint nx);
        if (p == PH_EXT_TYPE && nx + 4 > longint'(exts_end))
            mark_fail();
        else if (p == PH_NAME_TYPE && nx + 3 > longint'(list_end))
            mark_fail();
        else
        begin
            ph = p;
            fld_left = 2'd2;
            acc = '0;
        end
    endtask

    task automatic skip_or_enter(longint n, phase_t sp, longint nx);
        if (n == 0)
            enter_phase(phase_after_skip(sp), nx);
        else
        begin
            skip_left = n[23:0];
            ph = sp;
        end
    endtask

    // Shifts one byte into a two-byte length field; returns 1 when it is full.
    function automatic bit shift_pair(logic [7:0] b);
        acc = {8'd0, acc[7:0], b};
        if (fld_left > 0)
            fld_left--;
        return fld_left == 0;
    endfunction

    function automatic bit is_host_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_";
    endfunction

    // Predicts the result of one payload byte and queues it if one is due.
    task automatic predict_byte(logic [7:0] b, logic lst);
        longint  p;
        longint  nx;
        longint  v;
        bit      got_char;
        logic [6:0] ch;
        result_t r;
        p = pos;
        nx = p + 1;
        got_char = 1'b0;
        ch = '0;
        case (ph)
            PH_HDR:
            begin
                if (p == 0 && b != REC_HANDSHAKE)
                    mark_fail();
                else if (p == 5 && b != HS_CLIENT_HELLO)
                    mark_fail();
                else if (p >= 6)
                begin
                    acc = {acc[15:0], b};
                    if (p == 8)
                    begin
                        hs_end = 25'(9 + longint'(acc));
                        if (HELLO_FIXED_END + 1 > longint'(hs_end))
                            mark_fail();
                        else
                            skip_or_enter(34, PH_SKIP_RANDOM, nx);
                    end
                end
            end
            PH_SKIP_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_COMP, PH_SKIP_EXT,
            PH_SKIP_NAME:
            begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    enter_phase(phase_after_skip(ph), nx);
            end
            PH_SID_LEN, PH_COMP_LEN:
            begin
                if (nx + b + 2 > longint'(hs_end))
                    mark_fail();
                else
                    skip_or_enter(b, ph == PH_SID_LEN ? PH_SKIP_SID : PH_SKIP_COMP, nx);
            end
            PH_CS_LEN:
            begin
                if (shift_pair(b))
                begin
                    v = acc;
                    if (nx + v + 1 > longint'(hs_end))
                        mark_fail();
                    else
                        skip_or_enter(v, PH_SKIP_CS, nx);
                end
            end
            PH_EXTS_LEN:
            begin
                if (shift_pair(b))
                begin
                    v = acc;
                    if (nx + v > longint'(hs_end))
                        mark_fail();
                    else
                    begin
                        exts_end = 25'(nx + v);
                        enter_phase(PH_EXT_TYPE, nx);
                    end
                end
            end
            PH_EXT_TYPE:
            begin
                if (shift_pair(b))
                    enter_phase(acc[15:0] == EXT_SERVER_NAME ? PH_EXT_LEN_SNI
                                                             : PH_EXT_LEN_OTHER, nx);
            end
            PH_EXT_LEN_SNI, PH_EXT_LEN_OTHER:
            begin
                if (shift_pair(b))
                begin
                    v = acc;
                    if (nx + v > longint'(exts_end))
                        mark_fail();
                    else if (ph == PH_EXT_LEN_OTHER)
                        skip_or_enter(v, PH_SKIP_EXT, nx);
                    else if (v < 2)
                        mark_fail();
                    else
                    begin
                        ext_end = 25'(nx + v);
                        enter_phase(PH_LIST_LEN, nx);
                    end
                end
            end
            PH_LIST_LEN:
            begin
                if (shift_pair(b))
                begin
                    v = acc;
                    if (nx + v > longint'(ext_end))
                        mark_fail();
                    else
                    begin
                        list_end = 25'(nx + v);
                        enter_phase(PH_NAME_TYPE, nx);
                    end
                end
            end
            PH_NAME_TYPE:
                enter_phase(b == NAME_HOST ? PH_NAME_LEN_HOST : PH_NAME_LEN_OTHER, nx);
            PH_NAME_LEN_HOST, PH_NAME_LEN_OTHER:
            begin
                if (shift_pair(b))
                begin
                    v = acc;
                    if (nx + v > longint'(list_end))
                        mark_fail();
                    else if (ph == PH_NAME_LEN_OTHER)
                        skip_or_enter(v, PH_SKIP_NAME, nx);
                    else if (v == 0 || v > max_chars)
                        mark_fail();
                    else
                    begin
                        name_left = v[15:0];
                        ph = PH_NAME_CHARS;
                    end
                end
            end
            PH_NAME_CHARS:
            begin
                if (!is_host_char(b))
                    mark_fail();
                else
                begin
                    ch = (b >= "A" && b <= "Z") ? 7'(b + 32) : b[6:0];
                    got_char = 1'b1;
                    n_chars++;
                    if (name_left > 0)
                        name_left--;
                    if (name_left == 0)
                    begin
                        name_done = 1'b1;
                        ph = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        r = '0;
        if (lst)
        begin
            r.sni_found = name_done && !failed && (longint'(pos) + 1 >= longint'(hs_end));
            r.name_length = n_chars;
            r.verdict_done = 1'b1;
        end
        if (pos != POS_MAX)
            pos++;
        if (got_char || lst)
        begin
            r.name_char = ch;
            r.char_valid = got_char;
            sni_expected.push_back(r);
        end
        if (lst)
            clear_parse();
    endtask

    // Sends one byte, bursting with random gaps, and predicts it on acceptance.
    task automatic send_byte(logic [7:0] b, logic lst);
        if ($urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, lst);
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sni_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_chars(logic [7:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_chars = val;
    endtask

    function automatic byte unsigned rand_host_char();
        string set = "abcxyzABCXYZ0189-._";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Builds a ClientHello: an optional other extension and non-host entry before
    // the host name; trunc drops bytes from the end, extra appends padding.
    task automatic build_hello(int name_len, bit with_other, bit bad_char, int trunc,
                               int extra, bit upper_case);
        byte unsigned body[$];
        byte unsigned list[$];
        byte unsigned exts[$];
        int sid_len;
        int cs_len;
        int hl;
        body = {};
        list = {};
        exts = {};
        sid_len = $urandom_range(0, 8);
        cs_len = 2 * $urandom_range(1, 4);
        if (with_other)
        begin
            // A non-host entry in the server name list.
            list.push_back(8'd1); list.push_back(0); list.push_back(2);
            list.push_back($urandom); list.push_back($urandom);
        end
        list.push_back(NAME_HOST);
        list.push_back(name_len >> 8); list.push_back(name_len & 255);
        for (int i = 0; i < name_len; i++)
            list.push_back(upper_case ? "Q" : rand_host_char());
        if (bad_char && name_len > 0)
            list[list.size() - 1 - $urandom_range(0, name_len - 1)] = "/";
        if (with_other)
        begin
            exts.push_back(0); exts.push_back(8'h17); exts.push_back(0); exts.push_back(1);
            exts.push_back($urandom);
        end
        exts.push_back(0); exts.push_back(0);
        exts.push_back((list.size() + 2) >> 8); exts.push_back((list.size() + 2) & 255);
        exts.push_back(list.size() >> 8); exts.push_back(list.size() & 255);
        foreach (list[i]) exts.push_back(list[i]);
        // version + random
        for (int i = 0; i < 34; i++) body.push_back($urandom);
        body.push_back(sid_len);
        for (int i = 0; i < sid_len; i++) body.push_back($urandom);
        body.push_back(0); body.push_back(cs_len);
        for (int i = 0; i < cs_len; i++) body.push_back($urandom);
        body.push_back(1); body.push_back(0);
        body.push_back(exts.size() >> 8); body.push_back(exts.size() & 255);
        foreach (exts[i]) body.push_back(exts[i]);
        hl = body.size();
        pkt = {REC_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h00, HS_CLIENT_HELLO, 0,
               hl >> 8, hl & 255};
        foreach (body[i]) pkt.push_back(body[i]);
        for (int i = 0; i < extra; i++) pkt.push_back($urandom);
        while (trunc > 0 && pkt.size() > 1)
        begin
            void'(pkt.pop_back());
            trunc--;
        end
    endtask

    task automatic send_noise(int len);
        pkt = {};
        for (int i = 0; i < len; i++)
            pkt.push_back($urandom);
        if ($urandom_range(0, 1))
            pkt[0] = REC_HANDSHAKE;
        send_pkt();
    endtask

    // Well-formed hellos, an uppercase name, a non-host entry and extension ahead.
    task automatic test_directed_hellos();
        build_hello(5, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        build_hello(3, 1'b1, 1'b0, 0, 2, 1'b1); send_pkt();
        build_hello(1, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
    endtask

    // Broken hellos: bad char, short payload, wrong type bytes, single-byte payload.
    task automatic test_directed_errors();
        build_hello(4, 1'b0, 1'b1, 0, 0, 1'b0); send_pkt();
        build_hello(6, 1'b0, 1'b0, 3, 0, 1'b0); send_pkt();
        build_hello(4, 1'b0, 1'b0, 0, 0, 1'b0); pkt[0] = 8'h17; send_pkt();
        build_hello(4, 1'b0, 1'b0, 0, 0, 1'b0); pkt[5] = 8'h02; send_pkt();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // Name length limit at its extremes.
    task automatic test_name_limit();
        write_max_chars(8'd0);
        build_hello(2, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        write_max_chars(8'd1);
        build_hello(1, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        build_hello(2, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        write_max_chars(8'd255);
        build_hello(255, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        write_max_chars(8'd4);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 250)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                build_hello($urandom_range(1, 12), $urandom_range(0, 1),
                            $urandom_range(0, 7) == 0,
                            $urandom_range(0, 5) == 0 ? $urandom_range(1, 30) : 0,
                            $urandom_range(0, 3), $urandom_range(0, 7) == 0);
                // occasional random byte corruption
                if ($urandom_range(0, 5) == 0)
                    pkt[$urandom_range(0, pkt.size() - 1)] = $urandom;
                send_pkt();
            end
            else
            begin
                send_noise($urandom_range(1, 20));
            end
            sent += pkt.size();
            if ($urandom_range(0, 30) == 0)
                write_max_chars($urandom_range(1, 255));
        end
    endtask

    // Receiver holds off for a long time while the sender keeps going.
    task automatic test_backpressure();
        hold_off = 300;
        build_hello(10, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        build_hello(8, 1'b1, 1'b0, 0, 0, 1'b0); send_pkt();
        wait_drained();
    endtask

    // Receiver stall pattern with a long hold-off when requested.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (stall_enable)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= 1'b1;
        if (cycle_count % 2000 == 0)
            stall_enable <= ~stall_enable;
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sni_expected.size() == 0)
            begin
                $error("unexpected result tdata=%h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = sni_expected.pop_front();
                if (m_tdata[6:0] !== exp_r.name_char)
                begin
                    $error("name_char exp %h got %h", exp_r.name_char, m_tdata[6:0]);
                    error_count++;
                end
                if (m_tuser !== exp_r.char_valid)
                begin
                    $error("char_valid exp %b got %b", exp_r.char_valid, m_tuser);
                    error_count++;
                end
                if (m_tlast !== exp_r.verdict_done)
                begin
                    $error("verdict_done exp %b got %b", exp_r.verdict_done, m_tlast);
                    error_count++;
                end
                if (m_tdata[7] !== exp_r.sni_found)
                begin
                    $error("sni_found exp %b got %b", exp_r.sni_found, m_tdata[7]);
                    error_count++;
                end
                if (m_tdata[15:8] !== exp_r.name_length)
                begin
                    $error("name_length exp %0d got %0d", exp_r.name_length,
                           m_tdata[15:8]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        max_chars = MAX_NAME_RESET;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_hellos();
        test_directed_errors();
        test_name_limit();
        test_backpressure();
        test_random();
        write_max_chars(MAX_NAME_RESET);
        build_hello(3, 1'b0, 1'b0, 0, 0, 1'b0); send_pkt();
        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0 && sni_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sni_pkg.sv
rtl/sni_parser.sv
rtl/sni_queue.sv
rtl/tls_sni_host_extractor.sv
rtl/sni_checker.sv
tb/tb_top.sv
